// ----- sv/lbgm_pkg.sv -----
// Shared types, constants and reset values for the lidar beam grid marker.
`timescale 1ns / 1ps
package lbgm_pkg;

	localparam int GRID_WIDTH_DEF  = 512;
	localparam int GRID_HEIGHT_DEF = 512;

	localparam logic [15:0] RANGE_INF      = 16'hFFFF;
	localparam logic signed [16:0] TILT_MARGIN_MM = 17'sd6000;

	localparam logic [15:0] CPM_RST    = 16'd655;
	localparam logic [17:0] ORIGIN_RST = 18'd237144;
	localparam logic [15:0] MIN_RST    = 16'd100;
	localparam logic [15:0] MAX_RST    = 16'd12000;
	localparam logic [15:0] START_RST  = 16'h8000;
	localparam logic [15:0] STEP_RST   = 16'd182;

	localparam int PADDR_W = 5;

	typedef enum logic [2:0] {
		REG_CPM    = 3'd0,
		REG_ORIG_X = 3'd1,
		REG_ORIG_Y = 3'd2,
		REG_MIN    = 3'd3,
		REG_MAX    = 3'd4,
		REG_START  = 3'd5,
		REG_STEP   = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_MARKED    = 3'd0,
		ST_RANGE_REJ = 3'd1,
		ST_ROBOT_OFF = 3'd2,
		ST_BEAM_OFF  = 3'd3,
		ST_READ      = 3'd4
	} status_t;

	typedef enum logic {
		CLR_SWEEP,
		CLR_RUN
	} clr_state_t;

	typedef struct packed {
		logic [15:0] cells_per_mm_q16;
		logic [17:0] origin_x_mm;
		logic [17:0] origin_y_mm;
		logic [15:0] min_range_mm;
		logic [15:0] max_range_mm;
		logic [15:0] start_angle;
		logic [15:0] angle_step;
	} cfg_t;

	// pipeline control from the grid stage back to the geometry stages
	typedef struct packed {
		logic adv;
		logic accept;
	} pipe_ctl_t;

	// request leaving the geometry pipeline
	typedef struct packed {
		logic        valid;
		logic        is_read;
		logic        mark;
		logic        rd_ok;
		status_t     status;
		logic [17:0] cell_index;
	} geo_out_t;

endpackage

// ----- sv/lbgm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lbgm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/lbgm_regs.sv -----
// APB configuration registers.
`timescale 1ns / 1ps
module lbgm_regs import lbgm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cells_per_mm_q16 <= CPM_RST;
			cfg_q.origin_x_mm      <= ORIGIN_RST;
			cfg_q.origin_y_mm      <= ORIGIN_RST;
			cfg_q.min_range_mm     <= MIN_RST;
			cfg_q.max_range_mm     <= MAX_RST;
			cfg_q.start_angle      <= START_RST;
			cfg_q.angle_step       <= STEP_RST;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_CPM:    cfg_q.cells_per_mm_q16 <= pwdata[15:0];
				REG_ORIG_X: cfg_q.origin_x_mm      <= pwdata[17:0];
				REG_ORIG_Y: cfg_q.origin_y_mm      <= pwdata[17:0];
				REG_MIN:    cfg_q.min_range_mm     <= pwdata[15:0];
				REG_MAX:    cfg_q.max_range_mm     <= pwdata[15:0];
				REG_START:  cfg_q.start_angle      <= pwdata[15:0];
				REG_STEP:   cfg_q.angle_step       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CPM:    prdata = {16'b0, cfg_q.cells_per_mm_q16};
			REG_ORIG_X: prdata = {{14{cfg_q.origin_x_mm[17]}}, cfg_q.origin_x_mm};
			REG_ORIG_Y: prdata = {{14{cfg_q.origin_y_mm[17]}}, cfg_q.origin_y_mm};
			REG_MIN:    prdata = {16'b0, cfg_q.min_range_mm};
			REG_MAX:    prdata = {16'b0, cfg_q.max_range_mm};
			REG_START:  prdata = {{16{cfg_q.start_angle[15]}}, cfg_q.start_angle};
			REG_STEP:   prdata = {{16{cfg_q.angle_step[15]}}, cfg_q.angle_step};
			default:    prdata = 32'b0;
		endcase
	end

endmodule

// ----- sv/lbgm_geom.sv -----
// Thirteen-stage beam geometry pipeline: angle, sine/cosine, endpoint, cell, bounds.
`timescale 1ns / 1ps
module lbgm_geom import lbgm_pkg::*; #(
	parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  cfg_t                                      cfg,
	input  pipe_ctl_t                                 ctl,
	input  logic                                      req_type,
	input  logic [11:0]                               beam_index,
	input  logic [15:0]                               range_mm,
	input  logic signed [17:0]                        pose_x_mm,
	input  logic signed [17:0]                        pose_y_mm,
	input  logic signed [15:0]                        rot_xx,
	input  logic signed [15:0]                        rot_xy,
	input  logic signed [15:0]                        tilt_x,
	input  logic signed [15:0]                        rot_yx,
	input  logic signed [15:0]                        rot_yy,
	input  logic signed [15:0]                        tilt_y,
	input  logic [17:0]                               read_address,
	output geo_out_t                                  geo,
	output logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0] mem_addr
);

	localparam int CB = $clog2(GRID_WIDTH * GRID_HEIGHT);
	localparam int XB = $clog2(GRID_WIDTH);
	localparam int YB = $clog2(GRID_HEIGHT);
	localparam logic [31:0] CellCount = 32'(GRID_WIDTH * GRID_HEIGHT);
	localparam logic signed [19:0] RobLimX  = 20'(GRID_WIDTH);
	localparam logic signed [19:0] RobLimY  = 20'(GRID_HEIGHT);
	localparam logic signed [27:0] CellLimX = 28'(GRID_WIDTH);
	localparam logic signed [27:0] CellLimY = 28'(GRID_HEIGHT);

	typedef struct packed {
		logic               req;
		logic [17:0]        raddr;
		logic               rej;
		logic [15:0]        rng;
		logic [15:0]        ang;
		logic signed [18:0] dx;
		logic signed [18:0] dy;
		logic signed [15:0] rxx;
		logic signed [15:0] rxy;
		logic signed [15:0] tx;
		logic signed [15:0] ryx;
		logic signed [15:0] ryy;
		logic signed [15:0] ty;
		logic signed [19:0] robx;
		logic signed [19:0] roby;
		logic               roboff;
		logic [14:0]        xs;
		logic [14:0]        xc;
		logic               ns;
		logic               nc;
		logic [14:0]        x2s;
		logic [14:0]        x2c;
		logic [10:0]        t1s;
		logic [10:0]        t1c;
		logic [13:0]        t2s;
		logic [13:0]        t2c;
		logic signed [15:0] sn;
		logic signed [15:0] cs;
		logic signed [31:0] pax;
		logic signed [31:0] pbx;
		logic signed [31:0] pay;
		logic signed [31:0] pby;
		logic signed [33:0] drx;
		logic signed [33:0] dry;
		logic [32:0]        plx;
		logic signed [33:0] phx;
		logic [32:0]        ply;
		logic signed [33:0] phy;
		logic signed [39:0] offx;
		logic signed [39:0] offy;
		logic [33:0]        qlx;
		logic signed [38:0] qhx;
		logic [33:0]        qly;
		logic signed [38:0] qhy;
		logic signed [27:0] cx;
		logic signed [27:0] cy;
		status_t            status;
		logic               rd_ok;
		logic [17:0]        idx18;
		logic [CB-1:0]      maddr;
	} pipe_t;

	typedef struct packed {
		logic [14:0] x;
		logic        neg;
	} quad_t;

	function automatic quad_t quarter(input logic [15:0] a);
		quad_t r;
		r.x   = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
		r.neg = a[15];
		return r;
	endfunction

	pipe_t p_s1, p_s2, p_s3, p_s4, p_s5, p_s6, p_s7, p_s8, p_s9, p_s10, p_s11, p_s12, p_s13;
	pipe_t n1, n2, n3, n4, n5, n6, n7, n8, n9, n10, n11, n12, n13;
	logic [13:1] vld_s;

	// angle, origin offset, range gate
	always_comb begin
		logic signed [16:0] lim;
		n1 = p_s1;
		lim = $signed({1'b0, cfg.max_range_mm}) - TILT_MARGIN_MM;
		n1.req   = req_type;
		n1.raddr = read_address;
		n1.rng   = range_mm;
		n1.ang   = cfg.start_angle + {4'b0, beam_index} * cfg.angle_step;
		n1.dx    = $signed({pose_x_mm[17], pose_x_mm}) -
			$signed({cfg.origin_x_mm[17], cfg.origin_x_mm});
		n1.dy    = $signed({pose_y_mm[17], pose_y_mm}) -
			$signed({cfg.origin_y_mm[17], cfg.origin_y_mm});
		n1.rej   = (range_mm == RANGE_INF) || (range_mm < cfg.min_range_mm) ||
			($signed({1'b0, range_mm}) >= lim);
		n1.rxx = rot_xx;
		n1.rxy = rot_xy;
		n1.tx  = tilt_x;
		n1.ryx = rot_yx;
		n1.ryy = rot_yy;
		n1.ty  = tilt_y;
	end

	// robot cell, quarter-wave phase
	always_comb begin
		logic signed [35:0] prx, pry;
		quad_t qs, qc;
		n2 = p_s1;
		prx = p_s1.dx * $signed({1'b0, cfg.cells_per_mm_q16}) + 36'sd32768;
		pry = p_s1.dy * $signed({1'b0, cfg.cells_per_mm_q16}) + 36'sd32768;
		qs = quarter(p_s1.ang);
		qc = quarter(p_s1.ang + 16'd16384);
		n2.robx = prx[35:16];
		n2.roby = pry[35:16];
		n2.xs = qs.x;
		n2.ns = qs.neg;
		n2.xc = qc.x;
		n2.nc = qc.neg;
	end

	always_comb begin
		logic [29:0] ms, mc;
		n3 = p_s2;
		ms = p_s2.xs * p_s2.xs;
		mc = p_s2.xc * p_s2.xc;
		n3.x2s = ms[28:14];
		n3.x2c = mc[28:14];
		n3.roboff = p_s2.robx[19] || (p_s2.robx >= RobLimX) ||
			p_s2.roby[19] || (p_s2.roby >= RobLimY);
	end

	always_comb begin
		logic [25:0] ms, mc;
		n4 = p_s3;
		ms = p_s3.x2s * 11'd1160;
		mc = p_s3.x2c * 11'd1160;
		n4.t1s = ms[24:14];
		n4.t1c = mc[24:14];
	end

	always_comb begin
		logic [28:0] ms, mc;
		n5 = p_s4;
		ms = p_s4.x2s * (14'd10512 - {3'b0, p_s4.t1s});
		mc = p_s4.x2c * (14'd10512 - {3'b0, p_s4.t1c});
		n5.t2s = ms[27:14];
		n5.t2c = mc[27:14];
	end

	always_comb begin
		logic [29:0] ms, mc;
		n6 = p_s5;
		ms = p_s5.xs * (15'd25736 - {1'b0, p_s5.t2s});
		mc = p_s5.xc * (15'd25736 - {1'b0, p_s5.t2c});
		n6.sn = p_s5.ns ? -$signed({1'b0, ms[28:14]}) : $signed({1'b0, ms[28:14]});
		n6.cs = p_s5.nc ? -$signed({1'b0, mc[28:14]}) : $signed({1'b0, mc[28:14]});
	end

	always_comb begin
		n7 = p_s6;
		n7.pax = p_s6.rxx * p_s6.cs;
		n7.pbx = p_s6.rxy * p_s6.sn;
		n7.pay = p_s6.ryx * p_s6.cs;
		n7.pby = p_s6.ryy * p_s6.sn;
	end

	always_comb begin
		n8 = p_s7;
		n8.drx = 34'(p_s7.pax) + 34'(p_s7.pbx) + (34'(p_s7.tx) <<< 14);
		n8.dry = 34'(p_s7.pay) + 34'(p_s7.pby) + (34'(p_s7.ty) <<< 14);
	end

	// range times direction, split across the low and high halves of the direction
	always_comb begin
		n9 = p_s8;
		n9.plx = p_s8.rng * p_s8.drx[16:0];
		n9.phx = $signed({1'b0, p_s8.rng}) * $signed(p_s8.drx[33:17]);
		n9.ply = p_s8.rng * p_s8.dry[16:0];
		n9.phy = $signed({1'b0, p_s8.rng}) * $signed(p_s8.dry[33:17]);
	end

	always_comb begin
		logic signed [51:0] rx, ry, sx, sy;
		n10 = p_s9;
		rx = (52'(p_s9.phx) <<< 17) + $signed({19'b0, p_s9.plx});
		ry = (52'(p_s9.phy) <<< 17) + $signed({19'b0, p_s9.ply});
		sx = rx >>> 14;
		sy = ry >>> 14;
		n10.offx = $signed(sx[39:0]) + (40'(p_s9.dx) <<< 14);
		n10.offy = $signed(sy[39:0]) + (40'(p_s9.dy) <<< 14);
	end

	always_comb begin
		n11 = p_s10;
		n11.qlx = p_s10.offx[17:0] * cfg.cells_per_mm_q16;
		n11.qhx = $signed(p_s10.offx[39:18]) * $signed({1'b0, cfg.cells_per_mm_q16});
		n11.qly = p_s10.offy[17:0] * cfg.cells_per_mm_q16;
		n11.qhy = $signed(p_s10.offy[39:18]) * $signed({1'b0, cfg.cells_per_mm_q16});
	end

	// round half up to cells
	always_comb begin
		logic signed [57:0] sx, sy;
		n12 = p_s11;
		sx = (58'(p_s11.qhx) <<< 18) + $signed({24'b0, p_s11.qlx}) + 58'sd536870912;
		sy = (58'(p_s11.qhy) <<< 18) + $signed({24'b0, p_s11.qly}) + 58'sd536870912;
		n12.cx = sx[57:30];
		n12.cy = sy[57:30];
	end

	always_comb begin
		logic          offmap;
		logic [CB-1:0] idx;
		n13 = p_s12;
		offmap = p_s12.cx[27] || (p_s12.cx >= CellLimX) ||
			p_s12.cy[27] || (p_s12.cy >= CellLimY);
		idx = CB'(p_s12.cy[YB-1:0]) * CB'(GRID_WIDTH) + CB'(p_s12.cx[XB-1:0]);
		n13.rd_ok = (32'(p_s12.raddr) < CellCount);
		n13.idx18 = 18'b0;
		n13.maddr = idx;
		if (p_s12.req) begin
			n13.status = ST_READ;
			n13.idx18  = p_s12.raddr;
			n13.maddr  = CB'(p_s12.raddr);
		end else if (p_s12.roboff) begin
			n13.status = ST_ROBOT_OFF;
		end else if (p_s12.rej) begin
			n13.status = ST_RANGE_REJ;
		end else if (offmap) begin
			n13.status = ST_BEAM_OFF;
		end else begin
			n13.status = ST_MARKED;
			n13.idx18  = 18'(idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ctl.adv) begin
			vld_s <= {vld_s[12:1], ctl.accept};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			p_s1  <= n1;
			p_s2  <= n2;
			p_s3  <= n3;
			p_s4  <= n4;
			p_s5  <= n5;
			p_s6  <= n6;
			p_s7  <= n7;
			p_s8  <= n8;
			p_s9  <= n9;
			p_s10 <= n10;
			p_s11 <= n11;
			p_s12 <= n12;
			p_s13 <= n13;
		end
	end

	assign geo.valid      = vld_s[13];
	assign geo.is_read    = p_s13.req;
	assign geo.mark       = !p_s13.req && (p_s13.status == ST_MARKED);
	assign geo.rd_ok      = p_s13.rd_ok;
	assign geo.status     = p_s13.status;
	assign geo.cell_index = p_s13.idx18;
	assign mem_addr       = p_s13.maddr;

endmodule

// ----- sv/lbgm_grid.sv -----
// Occupancy bit grid: clearing sweep, mark and read access, output register.
`timescale 1ns / 1ps
module lbgm_grid import lbgm_pkg::*; #(
	parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  geo_out_t                                  geo,
	input  logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0] mem_addr,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	output pipe_ctl_t                                 ctl,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [2:0]                                status,
	output logic [17:0]                               cell_index,
	output logic                                      cell_occupied
);

	localparam int CB = $clog2(GRID_WIDTH * GRID_HEIGHT);
	localparam logic [CB-1:0] LastCell = CB'(GRID_WIDTH * GRID_HEIGHT - 1);

	clr_state_t state_q, state_d;
	logic [CB-1:0] cnt_q, cnt_d;
	logic sweep, adv, we, re, rdata;
	logic [CB-1:0] waddr;

	logic        vld_s14;
	status_t     st_s14;
	logic [17:0] idx_s14;
	logic        rd_s14;
	logic        rdok_s14;

	assign adv      = !vld_s14 || out_ready;
	assign in_ready = adv && (state_q == CLR_RUN);
	assign ctl.adv    = adv;
	assign ctl.accept = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		sweep   = 1'b0;
		unique case (state_q)
			CLR_SWEEP: begin
				sweep = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LastCell) begin
					state_d = CLR_RUN;
				end
			end
			CLR_RUN: ;
			default: state_d = CLR_SWEEP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLR_SWEEP;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign we    = sweep || (adv && geo.valid && geo.mark);
	assign waddr = sweep ? cnt_q : mem_addr;
	assign re    = adv && geo.valid && geo.is_read;

	lbgm_ram #(
		.WIDTH(1),
		.DEPTH(GRID_WIDTH * GRID_HEIGHT)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(!sweep),
		.re   (re),
		.raddr(mem_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s14 <= 1'b0;
		end else if (adv) begin
			vld_s14 <= geo.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s14   <= geo.status;
			idx_s14  <= geo.cell_index;
			rd_s14   <= geo.is_read;
			rdok_s14 <= geo.rd_ok;
		end
	end

	assign out_valid     = vld_s14;
	assign status        = st_s14;
	assign cell_index    = idx_s14;
	assign cell_occupied = rd_s14 ? (rdok_s14 && rdata) : (st_s14 == ST_MARKED);

endmodule

// ----- sv/lidar_beam_grid_marker.sv -----
// Top level of the lidar beam grid marker.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------------
//  request   | in_valid / in_ready  | req_type, beam_index, range_mm, pose, rotation
//  result    | out_valid / out_ready| status, cell_index, cell_occupied
//  config    | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// One request enters per cycle while in_ready is high; results leave in order.
// After reset the grid of GRID_WIDTH*GRID_HEIGHT cells (262144 by default) is swept
// clear at one cell per cycle; in_ready stays low until the sweep ends.
// All stages hold together while a result waits on out_ready; nothing is lost.
// Marks and reads touch the grid RAM at one stage, so they take effect in order.
`timescale 1ns / 1ps
module lidar_beam_grid_marker import lbgm_pkg::*; #(
	parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [11:0]        beam_index,
	input  logic [15:0]        range_mm,
	input  logic signed [17:0] pose_x_mm,
	input  logic signed [17:0] pose_y_mm,
	input  logic signed [15:0] rot_xx,
	input  logic signed [15:0] rot_xy,
	input  logic signed [15:0] tilt_x,
	input  logic signed [15:0] rot_yx,
	input  logic signed [15:0] rot_yy,
	input  logic signed [15:0] tilt_y,
	input  logic [17:0]        read_address,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [17:0]        cell_index,
	output logic               cell_occupied,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int CB = $clog2(GRID_WIDTH * GRID_HEIGHT);

	cfg_t          cfg;
	pipe_ctl_t     ctl;
	geo_out_t      geo;
	logic [CB-1:0] mem_addr;

	lbgm_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	lbgm_geom #(
		.GRID_WIDTH (GRID_WIDTH),
		.GRID_HEIGHT(GRID_HEIGHT)
	) u_geom (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.ctl         (ctl),
		.req_type    (req_type),
		.beam_index  (beam_index),
		.range_mm    (range_mm),
		.pose_x_mm   (pose_x_mm),
		.pose_y_mm   (pose_y_mm),
		.rot_xx      (rot_xx),
		.rot_xy      (rot_xy),
		.tilt_x      (tilt_x),
		.rot_yx      (rot_yx),
		.rot_yy      (rot_yy),
		.tilt_y      (tilt_y),
		.read_address(read_address),
		.geo         (geo),
		.mem_addr    (mem_addr)
	);

	lbgm_grid #(
		.GRID_WIDTH (GRID_WIDTH),
		.GRID_HEIGHT(GRID_HEIGHT)
	) u_grid (
		.clk          (clk),
		.arst_n       (arst_n),
		.geo          (geo),
		.mem_addr     (mem_addr),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.ctl          (ctl),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.cell_index   (cell_index),
		.cell_occupied(cell_occupied)
	);

endmodule

// ----- sim/tb.sv -----
// Testbench for the lidar beam grid marker: beam and read requests checked against a predictor.
`timescale 1ns / 1ps
module tb;
	import lbgm_pkg::*;

	localparam int GW = GRID_WIDTH_DEF;
	localparam int GH = GRID_HEIGHT_DEF;
	localparam int CELLS = GW * GH;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready;
	logic req_type = 0;
	logic [11:0] beam_index = 0;
	logic [15:0] range_mm = 0;
	logic signed [17:0] pose_x_mm = 0, pose_y_mm = 0;
	logic signed [15:0] rot_xx = 0, rot_xy = 0, tilt_x = 0, rot_yx = 0, rot_yy = 0, tilt_y = 0;
	logic [17:0] read_address = 0;
	logic out_valid, out_ready = 0;
	logic [2:0] status;
	logic [17:0] cell_index;
	logic cell_occupied;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [PADDR_W-1:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	logic pready;

	lidar_beam_grid_marker u_top (.*);

	always #1 clk = ~clk;

	typedef struct packed {
		logic [2:0]  st;
		logic [17:0] idx;
		logic        occ;
	} grid_result_t;

	grid_result_t result_q[$];
	bit grid_model[CELLS];
	longint m_cpm, m_ox, m_oy, m_min, m_max, m_start, m_step;
	int errors = 0;
	bit calm = 0;
	logic [17:0] marked_cells[$];

	function automatic longint fdiv(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint sin14(int unsigned a);
		int unsigned q, f;
		longint x, x2, t1, t2, s;
		q = (a >> 14) & 3;
		f = a & 16'h3FFF;
		x = (q & 1) ? 16384 - f : f;
		x2 = (x * x) >> 14;
		t1 = (x2 * 1160) >> 14;
		t2 = (x2 * (10512 - t1)) >> 14;
		s = (x * (25736 - t2)) >> 14;
		return (q >= 2) ? -s : s;
	endfunction

	function automatic longint axis_cell(longint pose, longint org, longint rng,
			longint ra, longint rb, longint tl, longint c, longint s);
		longint d, off;
		d = ra * c + rb * s + tl * 16384;
		off = (pose - org) * 16384 + fdiv(rng * d, 14);
		return fdiv(off * m_cpm + (64'sd1 <<< 29), 30);
	endfunction

	function automatic grid_result_t predict_cell();
		grid_result_t r;
		longint rx, ry, cx, cy, s, c;
		int unsigned ang;
		r = '0;
		if (req_type) begin
			r.st = ST_READ;
			r.idx = read_address;
			r.occ = (read_address < CELLS) ? grid_model[read_address] : 1'b0;
			return r;
		end
		rx = fdiv((longint'(pose_x_mm) - m_ox) * m_cpm + 32768, 16);
		ry = fdiv((longint'(pose_y_mm) - m_oy) * m_cpm + 32768, 16);
		if (rx < 0 || rx >= GW || ry < 0 || ry >= GH) r.st = ST_ROBOT_OFF;
		else if (range_mm == RANGE_INF || longint'(range_mm) < m_min ||
				longint'(range_mm) >= m_max - 6000)
			r.st = ST_RANGE_REJ;
		else begin
			ang = (m_start + longint'(beam_index) * m_step) & 16'hFFFF;
			s = sin14(ang);
			c = sin14((ang + 16384) & 16'hFFFF);
			cx = axis_cell(pose_x_mm, m_ox, range_mm, rot_xx, rot_xy, tilt_x, c, s);
			cy = axis_cell(pose_y_mm, m_oy, range_mm, rot_yx, rot_yy, tilt_y, c, s);
			if (cx < 0 || cx >= GW || cy < 0 || cy >= GH) r.st = ST_BEAM_OFF;
			else begin
				r.st = ST_MARKED;
				r.idx = cy * GW + cx;
				r.occ = 1;
				grid_model[cy * GW + cx] = 1;
				marked_cells = {marked_cells, 18'(cy * GW + cx)};
			end
		end
		return r;
	endfunction

	task automatic pause_sender();
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// Present one request; prediction is taken at acceptance, in order.
	task automatic send_request(bit rt, logic [11:0] bi, logic [15:0] rg,
			logic [17:0] px, logic [17:0] py, logic [15:0] a, logic [15:0] b,
			logic [15:0] t, logic [15:0] d, logic [15:0] e, logic [15:0] u,
			logic [17:0] ra);
		pause_sender();
		in_valid <= 1; req_type <= rt; beam_index <= bi; range_mm <= rg;
		pose_x_mm <= px; pose_y_mm <= py; rot_xx <= a; rot_xy <= b; tilt_x <= t;
		rot_yx <= d; rot_yy <= e; tilt_y <= u; read_address <= ra;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		result_q = {result_q, predict_cell()};
	endtask

	task automatic write_reg(reg_idx_t r, logic [31:0] v);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= PADDR_W'(4 * r); pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (r)
			REG_CPM:    m_cpm = v[15:0];
			REG_ORIG_X: m_ox = longint'($signed(v[17:0]));
			REG_ORIG_Y: m_oy = longint'($signed(v[17:0]));
			REG_MIN:    m_min = v[15:0];
			REG_MAX:    m_max = v[15:0];
			REG_START:  m_start = longint'($signed(v[15:0]));
			REG_STEP:   m_step = longint'($signed(v[15:0]));
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Level pose, identity rotation
	task automatic send_beam(logic [11:0] bi, logic [15:0] rg, logic [17:0] px, logic [17:0] py);
		send_request(0, bi, rg, px, py, 16384, 0, 0, 0, 16384, 0, $urandom);
	endtask

	task automatic send_read(logic [17:0] a);
		send_request(1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, a);
	endtask

	always @(posedge clk) begin
		if (calm) out_ready <= 1;
		else if ($urandom_range(0, 4) == 0) out_ready <= 0;
		else out_ready <= 1;
	end

	always @(posedge clk) begin
		grid_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				$display("%0t: result with none expected: got %0d %0d %0d", $time,
					status, cell_index, cell_occupied);
				errors++;
			end else begin
				e = result_q.pop_front();
				if (status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					errors++;
				end
				if (cell_index !== e.idx) begin
					$display("%0t: cell_index expected %0d actual %0d", $time, e.idx, cell_index);
					errors++;
				end
				if (cell_occupied !== e.occ) begin
					$display("%0t: cell_occupied expected %0d actual %0d", $time, e.occ,
						cell_occupied);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_beam(0, 1000, 0, 0);
		send_beam(4095, 5000, 0, 0);
		send_beam(100, RANGE_INF, 0, 0);
		send_beam(100, 99, 0, 0);
		send_beam(100, 100, 0, 0);
		send_beam(100, 5999, 0, 0);
		send_beam(100, 6000, 0, 0);
		send_beam(100, 0, 18'h1FFFF, 0);
		send_beam(100, 0, 0, 18'h20000);
		send_beam(100, 5000, 24000, 0);
		send_request(0, 12'hFFF, 3000, 100, -200, 16'h8000, 16'h7FFF, 16'h7FFF,
			16'h8000, 16'h7FFF, 16'h8000, 0);
		send_request(0, 7, 2000, 0, 0, -16384, 16384, -16384, 16384, -16384, 16384, 0);
		send_read(18'h3FFFF);
		send_read(0);
		drain();
		foreach (marked_cells[i]) send_read(marked_cells[i]);
		drain();
		write_reg(REG_MAX, 5000);
		send_beam(10, 1000, 0, 0);
		send_beam(10, 0, 0, 0);
		drain();
		write_reg(REG_MAX, 12000);
	endtask

	task automatic random_beams(int n);
		logic [17:0] a;
		repeat (n) begin
			case ($urandom_range(0, 9))
				0: send_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				1, 2: begin
					a = (marked_cells.size() != 0 && $urandom_range(0, 1))
						? marked_cells[$urandom_range(0, marked_cells.size() - 1)] : $urandom;
					send_read(a);
				end
				default: send_request(0, $urandom, $urandom_range(0, 7000),
					$urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000,
					$urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384,
					$urandom_range(0, 4000) - 2000, $urandom_range(0, 32768) - 16384,
					$urandom_range(0, 32768) - 16384, $urandom_range(0, 4000) - 2000, 0);
			endcase
		end
		drain();
	endtask

	task automatic test_settings();
		random_beams(120);
		write_reg(REG_CPM, 65535); write_reg(REG_ORIG_X, 18'h20000);
		write_reg(REG_ORIG_Y, 18'h1FFFF); write_reg(REG_MIN, 0);
		write_reg(REG_MAX, 65534); write_reg(REG_START, 16'h7FFF);
		write_reg(REG_STEP, 16'h8000);
		random_beams(60);
		write_reg(REG_CPM, 1); write_reg(REG_ORIG_X, 0); write_reg(REG_ORIG_Y, 0);
		write_reg(REG_MIN, 65534); write_reg(REG_MAX, 0); write_reg(REG_START, 0);
		write_reg(REG_STEP, 16'h7FFF);
		random_beams(40);
		write_reg(REG_CPM, 1311); write_reg(REG_ORIG_X, -12000);
		write_reg(REG_ORIG_Y, -12000); write_reg(REG_MIN, 50);
		write_reg(REG_MAX, 14000); write_reg(REG_START, $urandom);
		write_reg(REG_STEP, $urandom);
		random_beams(130);
		calm = 1;
		random_beams(100);
	endtask

	initial begin
		m_cpm = CPM_RST; m_ox = -25000; m_oy = -25000; m_min = MIN_RST;
		m_max = MAX_RST; m_start = -32768; m_step = STEP_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		test_directed();
		test_settings();
		if (errors == 0 && result_q.size() == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule

// ----- lidar_beam_grid_marker.f -----
sv/lbgm_pkg.sv
sv/lbgm_ram.sv
sv/lbgm_regs.sv
sv/lbgm_geom.sv
sv/lbgm_grid.sv
sv/lidar_beam_grid_marker.sv
sim/tb.sv
